@@ sv/url_percent_codec_assert.svh @@
`ifndef URL_PERCENT_CODEC_ASSERT_SVH
`define URL_PERCENT_CODEC_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define UPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define UPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/upc_pkg.sv @@
package upc_pkg;

	// mode register codes
	typedef enum logic [1:0] {
		MODE_ENC_COMP = 2'd0,
		MODE_ENC_URL  = 2'd1,
		MODE_DEC      = 2'd2,
		MODE_ENC_ALT  = 2'd3
	} mode_t;

	// decode escape tracking
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_DIG  = 2'd2
	} phase_t;

	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned CNT_W       = 2;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUEST = 8'h3F;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= 8'h61) && (c <= 8'h7A);
	endfunction

	// unreserved set; whole-URL mode adds a few delimiters
	function automatic logic is_safe(input logic [7:0] c, input logic whole);
		logic base;
		logic extra;
		base  = is_digit(c) || is_upper(c) || is_lower(c) || (c == CH_DASH) ||
			(c == CH_UNDER) || (c == CH_DOT) || (c == CH_TILDE);
		extra = (c == CH_COLON) || (c == CH_SLASH) || (c == CH_AMP) ||
			(c == CH_EQ) || (c == CH_QUEST);
		return base || (whole && extra);
	endfunction

	// uppercase hex character for one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

	// unvalidated hex value: c - '0' for a digit, else tolower(c) - 'a' + 10, wrapped to 8 bits
	function automatic logic [7:0] digit_value(input logic [7:0] c);
		logic [7:0] l;
		l = is_upper(c) ? (c + 8'd32) : c;
		return is_digit(c) ? (c - 8'h30) : (l - 8'h57);
	endfunction

endpackage

@@ sv/upc_if.sv @@
// input byte stream
interface upc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// result byte stream
interface upc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ sv/url_percent_codec.sv @@
// channel | dir | payload              | handshake
// rx      | in  | in_byte, in_last     | valid/ready
// tx      | out | out_byte, out_last   | valid/ready
// cfg     | in  | cfg_wdata (mode)     | cfg_we, no wait
//
// One result word leaves per cycle while tx is ready; an escaped encode-mode byte
// yields three result words, every other byte at most one, held in the three-entry
// expansion buffer that feeds the output register; a byte yielding none keeps rx ready.
// Reset clears mode, decode phase, held digit and both valid/count registers.
// A stalled tx holds the output register; rx then takes words until one that
// yields results sits in the buffer.
module url_percent_codec (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	upc_in_if.sink            rx,
	upc_out_if.source         tx
);
	import upc_pkg::*;

	mode_t                 mode_q;
	phase_t                phase_q;
	phase_t                phase_d;
	logic [7:0]            held_q;
	logic [7:0]            held_d;

	logic [CNT_W-1:0]      cnt_s1;
	logic [7:0]            buf_s1 [MAX_RESULTS];

	logic                  ov_q;
	logic [7:0]            ob_q;
	logic                  ol_q;

	logic                  acc;
	logic                  pop;
	logic [CNT_W-1:0]      n_d;
	logic [7:0]            b_d [MAX_RESULTS];

	logic [7:0]            c;

	assign c   = rx.in_byte;
	assign pop = (cnt_s1 != '0) && (!ov_q || tx.ready);
	assign rx.ready = (cnt_s1 == '0) || ((cnt_s1 == CNT_W'(1)) && pop);
	assign acc = rx.valid && rx.ready;

	assign tx.valid    = ov_q;
	assign tx.out_byte = ob_q;
	assign tx.out_last = ol_q;

	// results and next decode state for the word at the input
	always_comb begin
		logic [7:0] hi;
		hi      = digit_value(held_q);
		n_d     = '0;
		b_d[0]  = c;
		b_d[1]  = hex_char(c[7:4]);
		b_d[2]  = hex_char(c[3:0]);
		phase_d = phase_q;
		held_d  = held_q;
		if (mode_q != MODE_DEC) begin
			phase_d = PH_IDLE;
			if (is_safe(c, mode_q == MODE_ENC_URL)) begin
				n_d = CNT_W'(1);
			end else begin
				n_d    = CNT_W'(3);
				b_d[0] = CH_PCT;
			end
		end else if (phase_q == PH_PCT) begin
			if (rx.in_last) begin
				// escape cut short: drop the percent, treat this byte as plain
				phase_d = PH_IDLE;
				if (c == CH_PLUS) begin
					n_d    = CNT_W'(1);
					b_d[0] = CH_SPACE;
				end else if (c != CH_PCT) begin
					n_d = CNT_W'(1);
				end
			end else begin
				held_d  = c;
				phase_d = PH_DIG;
			end
		end else if (phase_q == PH_DIG) begin
			n_d     = CNT_W'(1);
			b_d[0]  = {hi[3:0], 4'h0} | digit_value(c);
			phase_d = PH_IDLE;
		end else begin
			if (c == CH_PCT) begin
				phase_d = PH_PCT;
			end else if (c == CH_PLUS) begin
				n_d    = CNT_W'(1);
				b_d[0] = CH_SPACE;
			end else begin
				n_d = CNT_W'(1);
			end
		end
		if (rx.in_last) begin
			phase_d = PH_IDLE;
		end
	end

	// mode register and decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ENC_COMP;
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (cfg_we) begin
			mode_q  <= mode_t'(cfg_wdata);
			phase_q <= PH_IDLE;
		end else if (acc) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	// expansion buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
		end else if (acc) begin
			cnt_s1 <= n_d;
		end else if (pop) begin
			cnt_s1 <= cnt_s1 - CNT_W'(1);
		end
	end

	// expansion buffer bytes, loaded on accept, else shifted toward entry 0 on a pop
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				buf_s1[i] <= b_d[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				buf_s1[i] <= buf_s1[i+1];
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (pop) begin
			ov_q <= 1'b1;
		end else if (tx.ready) begin
			ov_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			ob_q <= buf_s1[0];
			ol_q <= (cnt_s1 == CNT_W'(1));
		end
	end

`include "url_percent_codec_assert.svh"

	`UPC_ASSERT_NEXT(a_enc_count, acc && (mode_q != MODE_DEC), (cnt_s1 == CNT_W'(1)) || (cnt_s1 == CNT_W'(3)), "encode word must load one or three results")
	`UPC_ASSERT_NEXT(a_dec_count, acc && (mode_q == MODE_DEC), cnt_s1 <= CNT_W'(1), "decode word must load at most one result")
	`UPC_ASSERT_NEXT(a_last_flag, pop && (cnt_s1 == CNT_W'(1)), tx.valid && tx.out_last, "final buffered result must carry out_last")
	`UPC_ASSERT_NOW(a_phase_mode, phase_q != PH_IDLE, mode_q == MODE_DEC, "escape pending outside decode mode")

endmodule

@@ verif/upc_checker.sv @@
// Watches both byte channels and the mode port, predicts the result words of
// every accepted input word and compares them in order.
module upc_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	upc_in_if          rx,
	upc_out_if         tx,
	output int         fails,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import upc_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} word_t;

	word_t      expected_words[$];
	word_t      want;
	mode_t      cur_mode;
	phase_t     phase;
	logic [7:0] held;
	int         mismatch_count;

	// alphanumerics and - _ . ~ always pass; whole-URL mode adds : / & = ?
	function automatic logic passes_through(input logic [7:0] c, input logic whole);
		logic alnum;
		alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
		if (alnum || c == CH_DASH || c == CH_UNDER || c == CH_DOT || c == CH_TILDE)
			return 1'b1;
		return whole && (c == CH_COLON || c == CH_SLASH || c == CH_AMP ||
			c == CH_EQ || c == CH_QUEST);
	endfunction

	function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + n;
		return 8'h41 + n - 8'd10;
	endfunction

	// unvalidated: anything but 0-9 is lowercased and offset from 'a', mod 256
	function automatic logic [7:0] hex_value(input logic [7:0] c);
		logic [7:0] low;
		if (c >= 8'h30 && c <= 8'h39)
			return c - 8'h30;
		low = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
		return low - 8'h61 + 8'd10;
	endfunction

	// expected result words of one accepted input word
	task automatic predict(input logic [7:0] c, input logic last);
		logic [7:0] outs[$];
		logic [7:0] v;
		if (cur_mode != MODE_DEC) begin
			if (passes_through(c, cur_mode == MODE_ENC_URL)) begin
				outs.push_back(c);
			end else begin
				outs.push_back(CH_PCT);
				outs.push_back(nibble_ascii(c[7:4]));
				outs.push_back(nibble_ascii(c[3:0]));
			end
			phase = PH_IDLE;
		end else begin
			case (phase)
				PH_PCT: begin
					if (last) begin
						// escape cut short: '%' dropped, byte handled as plain
						if (c == CH_PLUS)
							outs.push_back(CH_SPACE);
						else if (c != CH_PCT)
							outs.push_back(c);
						phase = PH_IDLE;
					end else begin
						held  = c;
						phase = PH_DIG;
					end
				end
				PH_DIG: begin
					v = hex_value(held) << 4;
					v = v | hex_value(c);
					outs.push_back(v);
					phase = PH_IDLE;
				end
				default: begin
					if (c == CH_PCT)
						phase = last ? PH_IDLE : PH_PCT;
					else if (c == CH_PLUS)
						outs.push_back(CH_SPACE);
					else
						outs.push_back(c);
				end
			endcase
		end
		if (last)
			phase = PH_IDLE;
		foreach (outs[i])
			expected_words.push_back('{data: outs[i], last: (i == outs.size() - 1)});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode       = MODE_ENC_COMP;
			phase          = PH_IDLE;
			held           = '0;
			mismatch_count = 0;
			expected_words.delete();
			fails       <= 0;
			outstanding <= 0;
		end else begin
			// a mode write also abandons any pending escape
			if (cfg_we) begin
				cur_mode = mode_t'(cfg_wdata);
				phase    = PH_IDLE;
			end
			if (rx.valid && rx.ready)
				predict(rx.in_byte, rx.in_last);
			// result word against oldest expectation
			if (tx.valid && tx.ready) begin
				if (expected_words.size() == 0) begin
					$error("out_byte: no word expected, got %h", tx.out_byte);
					mismatch_count++;
				end else begin
					want = expected_words.pop_front();
					if (tx.out_byte !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, tx.out_byte);
						mismatch_count++;
					end
					if (tx.out_last !== want.last) begin
						$error("out_last: expected %b, got %b", want.last, tx.out_last);
						mismatch_count++;
					end
				end
			end
			fails       <= mismatch_count;
			outstanding <= expected_words.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import upc_pkg::*;

	localparam int LIMIT          = 200000;
	localparam int DRAIN          = 16;
	localparam int RAND_PER_PHASE = 45;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;
	logic       calm;
	int         cycle_count = 0;
	int         items_sent = 0;
	int         fails;
	int         outstanding;

	upc_in_if  rx_if();
	upc_out_if tx_if();

	url_percent_codec u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_if),
		.tx        (tx_if)
	);

	upc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.rx          (rx_if),
		.tx          (tx_if),
		.fails       (fails),
		.outstanding (outstanding)
	);

	always #4ns clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("** url_percent_codec: FAILED **");
			$finish;
		end
	end

	// calm stretches: no idling on either side
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			repeat ($urandom_range(40, 200)) @(posedge clk);
			calm <= ~calm;
		end
	end

	// result side: random stall before each word
	initial begin
		int gap;
		tx_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				tx_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tx_if.ready <= 1'b1;
			do @(posedge clk); while (!(tx_if.valid && tx_if.ready));
		end
	end

	// one input word, after a random gap; returns at the accepting edge
	task automatic send_word(input logic [7:0] b, input logic last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.in_byte <= b;
		rx_if.in_last <= last;
		do @(posedge clk); while (!rx_if.ready);
		items_sent++;
	endtask

	task automatic send_bytes(input logic [7:0] s[$]);
		foreach (s[i])
			send_word(s[i], i == s.size() - 1);
	endtask

	task automatic send_text(input string t);
		for (int i = 0; i < t.len(); i++)
			send_word(t[i], i == t.len() - 1);
	endtask

	// stop sending and let every expected word (and any silent work) finish
	task automatic drain();
		rx_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_mode(input mode_t m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] punct_char();
		case ($urandom_range(0, 12))
			0:       return CH_DASH;
			1:       return CH_UNDER;
			2:       return CH_DOT;
			3:       return CH_TILDE;
			4:       return CH_COLON;
			5:       return CH_SLASH;
			6:       return CH_AMP;
			7:       return CH_EQ;
			8:       return CH_QUEST;
			9:       return CH_PCT;
			10:      return CH_PLUS;
			11:      return CH_SPACE;
			default: return 8'h23;
		endcase
	endfunction

	function automatic logic [7:0] any_char();
		case ($urandom_range(0, 5))
			0:       return 8'h61 + 8'($urandom_range(0, 25));
			1:       return 8'h41 + 8'($urandom_range(0, 25));
			2:       return 8'h30 + 8'($urandom_range(0, 9));
			3:       return punct_char();
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [7:0] hex_digit_char();
		case ($urandom_range(0, 2))
			0:       return 8'h30 + 8'($urandom_range(0, 9));
			1:       return 8'h61 + 8'($urandom_range(0, 5));
			default: return 8'h41 + 8'($urandom_range(0, 5));
		endcase
	endfunction

	task automatic send_encode_string();
		logic [7:0] s[$];
		repeat ($urandom_range(1, 8))
			s.push_back(any_char());
		send_bytes(s);
	endtask

	// half well-formed escapes and plus signs, half noise, and some cut-off endings
	task automatic send_decode_string();
		logic [7:0] s[$];
		repeat ($urandom_range(1, 5)) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					s.push_back(CH_PCT);
					s.push_back(hex_digit_char());
					s.push_back(hex_digit_char());
				end
				4: s.push_back(CH_PLUS);
				5, 6, 7: s.push_back(any_char());
				8: begin
					s.push_back(CH_PCT);
					s.push_back(any_char());
					s.push_back(any_char());
				end
				default: s.push_back(8'($urandom_range(1, 255)));
			endcase
		end
		if ($urandom_range(0, 5) == 0 && s.size() > 1)
			void'(s.pop_back());
		send_bytes(s);
	endtask

	initial begin
		mode_t plan[6];
		int    sent_before;

		rx_if.valid   <= 1'b0;
		rx_if.in_byte <= '0;
		rx_if.in_last <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= MODE_ENC_COMP;
		calm          <= 1'b0;
		arst_n        <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// component encode: pass-through, escapes, zero and top byte
		set_mode(MODE_ENC_COMP);
		send_text("a~- /");
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);

		// whole-URL encode: extra delimiters pass, others still escaped
		drain();
		set_mode(MODE_ENC_URL);
		send_text(":?#");

		// decode: escape, plus, and escapes cut short by end of string
		drain();
		set_mode(MODE_DEC);
		send_text("%4a+");
		send_text("%");
		send_text("%+");
		send_text("%%");
		send_text("%%+");
		send_word(8'hFF, 1'b1);

		// mode write drops a half-read escape
		send_word(CH_PCT, 1'b0);
		send_word("A", 1'b0);
		drain();
		set_mode(MODE_DEC);
		send_text("41");

		// unused mode code encodes as component
		drain();
		set_mode(MODE_ENC_ALT);
		send_text("/");

		// random strings across modes
		plan[0] = MODE_DEC;
		plan[1] = MODE_ENC_COMP;
		plan[2] = MODE_ENC_URL;
		plan[3] = MODE_DEC;
		plan[4] = MODE_ENC_ALT;
		plan[5] = MODE_DEC;
		foreach (plan[p]) begin
			drain();
			set_mode(plan[p]);
			sent_before = items_sent;
			while (items_sent - sent_before < RAND_PER_PHASE) begin
				if (plan[p] == MODE_DEC)
					send_decode_string();
				else
					send_encode_string();
			end
		end

		drain();
		if (fails == 0) begin
			$display("** url_percent_codec: PASSED **");
		end else begin
			$display("** url_percent_codec: FAILED **");
		end
		$finish;
	end

endmodule
